[hw/rtl/vpa_pkg.sv]
// Package with the allocator's constants, types and status codes.
package vpa_pkg;

  localparam int unsigned Partitions = 16;
  localparam int unsigned AddrBits   = 16;
  localparam int unsigned IdBits     = 8;
  localparam int unsigned IdxBits    = $clog2(Partitions);
  localparam int unsigned CntBits    = $clog2(Partitions + 1);
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 16;
  localparam logic [AddrBits-1:0] PoolReset = AddrBits'(640);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFitPolicy = 1'b0,
    CfgPoolSize  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StDup      = 3'd1,
    StNoFit    = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4,
    StBad      = 3'd5
  } status_e;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] size;
    logic [IdBits-1:0]   id;
    logic                used;
  } part_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  job_id;
    logic [15:0] request_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_address;
    logic [15:0] block_size;
  } rsp_t;

  typedef enum logic [3:0] {
    SIdle,
    SInit,
    SScan,
    SScanLast,
    SDecide,
    SShiftRd,
    SShiftWr,
    SPickWr,
    SFreeRd,
    SFreeMerge,
    SPackRd,
    SPackWr,
    SDone
  } state_e;

  // Memory port request issued by the sequencer.
  typedef struct packed {
    logic               re;
    logic [IdxBits-1:0] raddr;
    logic               we;
    logic [IdxBits-1:0] waddr;
    part_t              wdata;
  } mem_req_t;

endpackage

[hw/rtl/vpa_if.sv]
// Valid/ready channel interface carrying one payload.
interface vpa_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/variable_partition_allocator_core.sv]
// Top level of the variable partition allocator.
//  channel  | dir | payload
//  req      | in  | kind, job_id, request_size
//  rsp      | out | status, start_address, block_size
// A request scans the table entry by entry, then decides, then shifts or packs entries
// through the single read port, each entry read and then written back, before the
// response is made valid.
// After reset and after a pool_size write the SInit state rebuilds the table as a single free entry.
// A waiting response holds the request side until it is transferred.
module variable_partition_allocator_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [vpa_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [vpa_pkg::CfgDataBits-1:0] cfg_data_i,
  vpa_if.sink   req,
  vpa_if.source rsp
);
  import vpa_pkg::*;

  mem_req_t mem_req;
  part_t    rdata;

  vpa_table_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  vpa_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .req_i       (req.data),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp.data),
    .mem_o       (mem_req),
    .rdata_i     (rdata)
  );

endmodule

[hw/rtl/vpa_table_ram.sv]
// Partition table memory with one write port and one registered read port.
module vpa_table_ram (
  input  logic              clk_i,
  input  vpa_pkg::mem_req_t req_i,
  output vpa_pkg::part_t    rdata_o
);
  import vpa_pkg::*;

  part_t mem [Partitions];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

[hw/rtl/vpa_seq.sv]
// Sequencer that scans, splits, shifts and merges partition table entries.
module vpa_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vpa_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [vpa_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  vpa_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output vpa_pkg::rsp_t               rsp_o,
  output vpa_pkg::mem_req_t           mem_o,
  input  vpa_pkg::part_t              rdata_i
);
  import vpa_pkg::*;

  state_e state_q, state_d;
  logic   fit_q;
  logic [AddrBits-1:0] pool_q;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  req_t   req_q;
  logic [IdxBits-1:0]  ptr_q, ptr_d;
  logic [CntBits-1:0]  rd_q, rd_d;
  logic                dup_q, dup_d;
  logic                fnd_q, fnd_d;
  logic                exact_q, exact_d;
  logic [IdxBits-1:0]  pick_q, pick_d;
  part_t               pe_q, pe_d;
  part_t               prev_q, prev_d;
  logic                prev_ok_q, prev_ok_d;
  logic [IdxBits-1:0]  prev_ix_q, prev_ix_d;
  logic                next_ok_q, next_ok_d;
  part_t               next_q, next_d;
  logic [1:0]          del_q, del_d;
  logic [2:0]          st_q, st_d;
  logic [AddrBits-1:0] ra_q, ra_d, rs_q, rs_d;
  logic                rv_q, rv_d;
  logic [IdBits-1:0]   idm;
  logic [CntBits-1:0]  cidx;
  logic                cfg_pool;

  assign idm  = req_q.job_id[IdBits-1:0];
  assign cidx = CntBits'(ptr_q);
  assign cfg_pool = cfg_we_i && (cfg_idx_i == CfgPoolSize);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (req_valid_i && !rv_q) begin
          state_d = (cnt_q == CntBits'(1)) ? SScanLast : SScan;
        end
      end
      SInit: state_d = SIdle;
      SScan: begin
        if (rd_q + CntBits'(1) >= cnt_q) begin
          state_d = SScanLast;
        end
      end
      SScanLast: state_d = SDecide;
      SDecide: begin
        if (st_d != StOk) begin
          state_d = SDone;
        end else if (req_q.kind) begin
          state_d = SFreeRd;
        end else if (exact_q || CntBits'(pick_q) + CntBits'(1) >= cnt_q) begin
          state_d = SPickWr;
        end else begin
          state_d = SShiftRd;
        end
      end
      SShiftRd: state_d = SShiftWr;
      SShiftWr: state_d = (ptr_q == pick_q + IdxBits'(1)) ? SPickWr : SShiftRd;
      SPickWr: state_d = SDone;
      SFreeRd: state_d = SFreeMerge;
      SFreeMerge: state_d = (del_d != 2'd0 && rd_d < cnt_q) ? SPackRd : SDone;
      SPackRd: state_d = SPackWr;
      SPackWr: state_d = (rd_q + CntBits'(1) < cnt_q) ? SPackRd : SDone;
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
    if (cfg_pool) begin
      state_d = SInit;
    end
  end

  always_comb begin
    mem_o = '0;
    cnt_d = cnt_q; ptr_d = ptr_q; rd_d = rd_q;
    dup_d = dup_q; fnd_d = fnd_q; exact_d = exact_q; pick_d = pick_q;
    pe_d = pe_q; prev_d = prev_q; prev_ok_d = prev_ok_q; prev_ix_d = prev_ix_q;
    next_ok_d = next_ok_q; next_d = next_q; del_d = del_q;
    st_d = st_q; ra_d = ra_q; rs_d = rs_q; rv_d = rv_q;
    req_ready_o = 1'b0;
    if (rv_q && rsp_ready_i) begin
      rv_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        req_ready_o = !rv_q;
        mem_o.re = 1'b1;
        mem_o.raddr = '0;
        rd_d = CntBits'(1);
        dup_d = 1'b0; fnd_d = 1'b0; exact_d = 1'b0; pick_d = '0; ptr_d = '0;
      end
      SInit: begin
        mem_o.we = 1'b1;
        mem_o.waddr = '0;
        mem_o.wdata = '{start: '0, size: pool_q, id: '0, used: 1'b0};
        cnt_d = CntBits'(1);
      end
      SScan, SScanLast: begin
        if (state_q == SScan) begin
          mem_o.re = 1'b1;
          mem_o.raddr = rd_q[IdxBits-1:0];
          rd_d = rd_q + CntBits'(1);
        end
        if (rdata_i.used && rdata_i.id == idm) begin
          if (!dup_q) begin
            dup_d = 1'b1;
            pick_d = ptr_q;
            pe_d = rdata_i;
          end
        end else if (!req_q.kind && !rdata_i.used && rdata_i.size >= req_q.request_size
                     && !dup_q && !(fnd_q && (!fit_q || exact_q))) begin
          if (!fnd_q || !fit_q || rdata_i.size == req_q.request_size
              || rdata_i.size < pe_q.size) begin
            fnd_d = 1'b1;
            pick_d = ptr_q;
            pe_d = rdata_i;
            exact_d = rdata_i.size == req_q.request_size;
          end
        end
        ptr_d = ptr_q + IdxBits'(1);
      end
      SDecide: begin
        ra_d = '0; rs_d = '0;
        if (idm == '0 || (!req_q.kind && req_q.request_size == '0)) begin
          st_d = StBad;
        end else if (req_q.kind) begin
          st_d = dup_q ? StOk : StNotFound;
          if (dup_q) begin
            ra_d = pe_q.start; rs_d = pe_q.size;
          end
        end else if (dup_q) begin
          st_d = StDup;
        end else if (!fnd_q) begin
          st_d = StNoFit;
        end else if (!exact_q && cnt_q >= CntBits'(Partitions)) begin
          st_d = StFull;
        end else begin
          st_d = StOk;
          ra_d = pe_q.start; rs_d = req_q.request_size;
        end
        ptr_d = cnt_q[IdxBits-1:0];
        if (st_d == StOk && !req_q.kind && !exact_q) begin
          if (CntBits'(pick_q) + CntBits'(1) >= cnt_q) begin
            mem_o.we = 1'b1;
            mem_o.waddr = pick_q + IdxBits'(1);
            mem_o.wdata = '{start: pe_q.start + req_q.request_size,
                            size: pe_q.size - req_q.request_size, id: '0, used: 1'b0};
          end
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      SShiftRd: begin
        mem_o.re = 1'b1;
        mem_o.raddr = ptr_q - IdxBits'(1);
      end
      SShiftWr: begin
        mem_o.we = 1'b1;
        mem_o.waddr = ptr_q;
        mem_o.wdata = rdata_i;
        if (ptr_q == pick_q + IdxBits'(1)) begin
          mem_o.wdata = '{start: pe_q.start + req_q.request_size,
                          size: pe_q.size - req_q.request_size, id: '0, used: 1'b0};
        end
        ptr_d = ptr_q - IdxBits'(1);
      end
      SPickWr: begin
        mem_o.we = 1'b1;
        mem_o.waddr = pick_q;
        mem_o.wdata = '{start: pe_q.start, size: req_q.request_size, id: idm, used: 1'b1};
      end
      SFreeRd: begin
        prev_ok_d = 1'b0;
        mem_o.re = 1'b1;
        mem_o.raddr = pick_q - IdxBits'(1);
      end
      SFreeMerge: begin
        prev_d = rdata_i;
        prev_ok_d = pick_q != '0 && !rdata_i.used;
        mem_o.re = 1'b0;
        del_d = 2'd0;
        next_ok_d = 1'b0;
      end
      SPackRd: begin
        mem_o.re = 1'b1;
        mem_o.raddr = rd_q[IdxBits-1:0];
      end
      SPackWr: begin
        mem_o.we = 1'b1;
        mem_o.waddr = rd_q[IdxBits-1:0] - IdxBits'(del_q);
        mem_o.wdata = rdata_i;
        rd_d = rd_q + CntBits'(1);
        if (rd_q + CntBits'(1) >= cnt_q) begin
          cnt_d = cnt_q - CntBits'(del_q);
        end
      end
      SDone: begin
        rv_d = 1'b1;
      end
      default: ;
    endcase
    if (state_q == SFreeMerge) begin
      // The entry after the freed one was latched during the scan below.
      if (prev_ok_d) begin
        prev_ix_d = pick_q - IdxBits'(1);
      end else begin
        prev_ix_d = pick_q;
      end
      del_d = 2'(prev_ok_d) + 2'(next_ok_q);
      mem_o.we = 1'b1;
      mem_o.waddr = prev_ix_d;
      mem_o.wdata = '{start: prev_ok_d ? rdata_i.start : pe_q.start,
                      size: (prev_ok_d ? rdata_i.size : '0) + pe_q.size
                            + (next_ok_q ? next_q.size : '0),
                      id: '0, used: 1'b0};
      rd_d = CntBits'(pick_q) + CntBits'(1) + CntBits'(next_ok_q);
      if (del_d != 2'd0 && rd_d >= cnt_q) begin
        cnt_d = cnt_q - CntBits'(del_d);
      end
    end
    if ((state_q == SScan || state_q == SScanLast) && dup_q && !next_ok_q
        && ptr_q == pick_q + IdxBits'(1) && cidx < cnt_q) begin
      next_ok_d = !rdata_i.used;
      next_d = rdata_i;
    end
    if (state_q == SIdle) begin
      next_ok_d = 1'b0;
    end
    if (cfg_pool) begin
      cnt_d = CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      fit_q <= 1'b1;
      pool_q <= PoolReset;
      cnt_q <= CntBits'(1);
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      rv_q <= rv_d;
      if (cfg_we_i && cfg_idx_i == CfgFitPolicy) begin
        fit_q <= cfg_data_i[0];
      end
      if (cfg_pool) begin
        pool_q <= cfg_data_i[AddrBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      req_q <= req_i;
    end
    ptr_q <= ptr_d; rd_q <= rd_d; dup_q <= dup_d; fnd_q <= fnd_d;
    exact_q <= exact_d; pick_q <= pick_d; pe_q <= pe_d; prev_q <= prev_d;
    prev_ok_q <= prev_ok_d; prev_ix_q <= prev_ix_d; next_ok_q <= next_ok_d;
    next_q <= next_d; del_q <= del_d; st_q <= st_d; ra_q <= ra_d; rs_q <= rs_d;
  end

  assign rsp_valid_o = rv_q;
  assign rsp_o = '{status: st_q, start_address: ra_q, block_size: rs_q};

endmodule

[tb/variable_partition_allocator_core_tb.sv]
// Testbench for the variable partition allocator with directed and random requests.
`timescale 1ns / 1ps
module variable_partition_allocator_core_tb;
  import vpa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = CfgFitPolicy;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  vpa_if #(.T(req_t)) req ();
  vpa_if #(.T(rsp_t)) rsp ();

  variable_partition_allocator_core i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #5 clk_i = ~clk_i;

  part_t pool_tbl[Partitions];
  int unsigned pool_cnt;
  logic policy_q;
  logic [15:0] pool_q;
  rsp_t pending_rsp[$];
  int unsigned errors = 0;
  int unsigned idle_cnt = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit req_valid_q = 1'b0;

  function automatic void pool_init();
    foreach (pool_tbl[i]) pool_tbl[i] = '0;
    pool_tbl[0].size = pool_q;
    pool_cnt = 1;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < pool_cnt; i++) pool_tbl[i] = pool_tbl[i + 1];
    pool_cnt--;
  endfunction

  function automatic rsp_t predict_alloc(logic [7:0] id, logic [15:0] sz);
    rsp_t r;
    int pick;
    bit found;
    r = '0;
    pick = -1;
    found = 1'b0;
    for (int unsigned i = 0; i < pool_cnt; i++)
      if (pool_tbl[i].used && pool_tbl[i].id == id) begin
        r.status = StDup;
        return r;
      end
    for (int unsigned i = 0; i < pool_cnt; i++) begin
      if (pool_tbl[i].used || pool_tbl[i].size < sz) continue;
      if (!policy_q || pool_tbl[i].size == sz) begin
        pick = i;
        found = 1'b1;
        break;
      end
      if (!found || pool_tbl[i].size < pool_tbl[pick].size) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      r.status = StNoFit;
      return r;
    end
    if (pool_tbl[pick].size != sz) begin
      if (pool_cnt >= Partitions) begin
        r.status = StFull;
        return r;
      end
      for (int i = pool_cnt; i > pick; i--) pool_tbl[i] = pool_tbl[i - 1];
      pool_cnt++;
      pool_tbl[pick + 1].start = pool_tbl[pick].start + sz;
      pool_tbl[pick + 1].size = pool_tbl[pick + 1].size - sz;
      pool_tbl[pick].size = sz;
    end
    pool_tbl[pick].used = 1'b1;
    pool_tbl[pick].id = id;
    r.status = StOk;
    r.start_address = pool_tbl[pick].start;
    r.block_size = sz;
    return r;
  endfunction

  function automatic rsp_t predict_release(logic [7:0] id);
    rsp_t r;
    int idx;
    r = '0;
    idx = -1;
    for (int unsigned i = 0; i < pool_cnt; i++)
      if (pool_tbl[i].used && pool_tbl[i].id == id) begin
        idx = i;
        break;
      end
    if (idx < 0) begin
      r.status = StNotFound;
      return r;
    end
    r.status = StOk;
    r.start_address = pool_tbl[idx].start;
    r.block_size = pool_tbl[idx].size;
    pool_tbl[idx].used = 1'b0;
    pool_tbl[idx].id = '0;
    if (idx + 1 < pool_cnt && !pool_tbl[idx + 1].used) begin
      pool_tbl[idx].size += pool_tbl[idx + 1].size;
      drop_entry(idx + 1);
    end
    if (idx > 0 && !pool_tbl[idx - 1].used) begin
      pool_tbl[idx - 1].size += pool_tbl[idx].size;
      drop_entry(idx);
    end
    return r;
  endfunction

  function automatic rsp_t predict_request(req_t q);
    rsp_t r;
    r = '0;
    r.status = StBad;
    if (!q.kind && q.job_id != 0 && q.request_size != 0)
      r = predict_alloc(q.job_id, q.request_size);
    else if (q.kind && q.job_id != 0) r = predict_release(q.job_id);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected transfer %p", $time, rsp.data);
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.data.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.data.status);
        if (rsp.data.start_address !== e.start_address)
          $display("%0t: start expected %0d actual %0d", $time, e.start_address,
                   rsp.data.start_address);
        if (rsp.data.block_size !== e.block_size)
          $display("%0t: size expected %0d actual %0d", $time, e.block_size, rsp.data.block_size);
        if (rsp.data !== e) errors++;
      end
    end
  end

  always @(negedge clk_i) rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
  initial rsp.ready = 1'b0;

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_request(logic kind, logic [7:0] id, logic [15:0] sz);
    req_t q;
    q.kind = kind;
    q.job_id = id;
    q.request_size = sz;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk_i);
    req.valid <= 1'b1;
    req.data <= q;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp.push_back(predict_request(q));
    @(negedge clk_i);
    req.valid <= 1'b0;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgFitPolicy) policy_q = val[0];
    else begin
      pool_q = val;
      pool_init();
    end
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_request(1'b0, 8'd0, 16'd5);
    send_request(1'b0, 8'd1, 16'd0);
    send_request(1'b1, 8'd0, 16'd0);
    send_request(1'b1, 8'd9, 16'd0);
    send_request(1'b0, 8'd1, 16'd100);
    send_request(1'b0, 8'd1, 16'd10);
    send_request(1'b0, 8'd2, 16'd50);
    send_request(1'b0, 8'd3, 16'd200);
    send_request(1'b0, 8'd255, 16'hFFFF);
    send_request(1'b1, 8'd1, 16'hFFFF);
    send_request(1'b0, 8'd4, 16'd40);
    send_request(1'b1, 8'd3, 16'd0);
    send_request(1'b0, 8'd5, 16'd290);
    send_request(1'b1, 8'd2, 16'd0);
    send_request(1'b1, 8'd4, 16'd0);
    send_request(1'b1, 8'd5, 16'd0);
    write_reg(CfgFitPolicy, 16'd0);
    write_reg(CfgPoolSize, 16'd20);
    for (int i = 1; i <= 17; i++) send_request(1'b0, 8'(i), 16'd1);
  endtask

  task automatic test_edges();
    write_reg(CfgPoolSize, 16'd0);
    send_request(1'b0, 8'd7, 16'd1);
    write_reg(CfgPoolSize, 16'hFFFF);
    send_request(1'b0, 8'd128, 16'hFFFF);
    send_request(1'b1, 8'd128, 16'd0);
  endtask

  task automatic test_random(int n, int idle, int stall, logic pol, logic [15:0] psz);
    logic [7:0] id;
    logic [15:0] sz;
    src_idle_pct = idle;
    snk_stall_pct = stall;
    write_reg(CfgFitPolicy, {15'd0, pol});
    write_reg(CfgPoolSize, psz);
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(12));
      case ($urandom_range(9))
        0: sz = 16'($urandom);
        1: sz = 16'($urandom_range(3));
        default: sz = 16'($urandom_range(1, psz / 6 + 2));
      endcase
      send_request($urandom_range(99) < 40, id, sz);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    policy_q = 1'b1;
    pool_q = PoolReset;
    pool_init();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_edges();
    test_random(140, 0, 0, 1'b1, 16'd640);
    test_random(100, 80, 0, 1'b0, 16'd300);
    test_random(100, 0, 80, 1'b1, 16'd64);
    test_random(110, 29, 29, 1'b0, 16'd65535);
    test_random(60, 0, 0, 1'b1, 16'd1);
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
